// ===== design/kle_pkg.sv =====
package kle_pkg;

  // Config register indexes
  localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW        = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH       = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH     = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // Stream byte that holds the header length
  localparam logic [7:0] HDR_LEN_POS   = 8'd10;
  // Last bit index of a byte
  localparam logic [2:0] LAST_BIT      = 3'd7;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LENGTH = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_BITS   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]   message_length;
    logic [127:0] key;            // key byte k in bits 8k+7..8k
    logic [4:0]   key_length;
  } kle_cfg_t;

  typedef struct packed {
    logic       embed_done;
    logic       message_taken;
    logic [7:0] stego_byte;
  } kle_res_t;

endpackage

// ===== design/kle_cfg.sv =====
module kle_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kle_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [kle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output kle_pkg::kle_cfg_t                 cfg
);
  import kle_pkg::*;

  logic [7:0]  msg_len_r;
  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [4:0]  key_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r  <= '0;
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MESSAGE_LENGTH: msg_len_r  <= cfg_wdata[7:0];
        REG_KEY_LOW:        key_low_r  <= cfg_wdata;
        REG_KEY_HIGH:       key_high_r <= cfg_wdata;
        REG_KEY_LENGTH:     key_len_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.message_length = msg_len_r;
  assign cfg.key            = {key_high_r, key_low_r};
  assign cfg.key_length     = key_len_r;

endmodule

// ===== design/kle_core.sv =====
module kle_core #(
  parameter int KEY_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,      // item accepted this cycle
  input  logic [7:0]        image_byte,
  input  logic [7:0]        message_byte,
  input  kle_pkg::kle_cfg_t cfg,
  output kle_pkg::kle_res_t res
);
  import kle_pkg::*;

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  phase_t            phase_r,  phase_nxt;
  logic [7:0]        bpos_r,   bpos_nxt;
  logic [7:0]        hlen_r,   hlen_nxt;
  logic [7:0]        skip_r,   skip_nxt;
  logic [2:0]        bidx_r,   bidx_nxt;
  logic [7:0]        shift_r,  shift_nxt;
  logic [7:0]        chars_r,  chars_nxt;
  logic [KIDX_W-1:0] kidx_r,   kidx_nxt;

  // Next-character setup
  logic [4:0]        n_eff;
  logic [KIDX_W-1:0] ki0;
  logic [KIDX_W:0]   ki1;
  logic [KIDX_W-1:0] sn_kidx;
  logic [7:0]        sn_skip;
  phase_t            sn_phase;

  logic [7:0] hl_eff;
  logic [8:0] p_inc;
  logic [7:0] b;
  logic [7:0] chars_inc;
  logic [7:0] skip_dec;

  always_comb begin
    n_eff = (cfg.key_length > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : cfg.key_length;
    ki0   = (5'(kidx_r) >= n_eff) ? '0 : kidx_r;
    ki1   = {1'b0, ki0} + (KIDX_W+1)'(1);
    if (n_eff != '0) begin
      sn_skip = cfg.key[{4'(ki0), 3'b000} +: 8];
      sn_kidx = (5'(ki1) >= n_eff) ? '0 : ki1[KIDX_W-1:0];
    end else begin
      sn_skip = '0;
      sn_kidx = kidx_r;
    end
    sn_phase = (sn_skip != '0) ? PH_SKIP : PH_BITS;
  end

  assign hl_eff    = (bpos_r == HDR_LEN_POS) ? image_byte : hlen_r;
  assign p_inc     = {1'b0, bpos_r} + 9'd1;
  assign b         = (bidx_r == '0) ? message_byte : shift_r;
  assign chars_inc = chars_r + 8'd1;
  assign skip_dec  = skip_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    bpos_nxt  = bpos_r;
    hlen_nxt  = hlen_r;
    skip_nxt  = skip_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    chars_nxt = chars_r;
    kidx_nxt  = kidx_r;
    res.stego_byte    = image_byte;
    res.message_taken = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        hlen_nxt = hl_eff;
        if (bpos_r >= HDR_LEN_POS && p_inc >= {1'b0, hl_eff}) begin
          bidx_nxt  = '0;
          phase_nxt = PH_LENGTH;
        end else begin
          bpos_nxt = p_inc[7:0];
        end
      end
      PH_LENGTH: begin
        res.stego_byte = {image_byte[7:1], cfg.message_length[bidx_r]};
        if (bidx_r == LAST_BIT) begin
          bidx_nxt = '0;
          if (chars_r >= cfg.message_length) begin
            phase_nxt = PH_DONE;
          end else begin
            skip_nxt  = sn_skip;
            kidx_nxt  = sn_kidx;
            phase_nxt = sn_phase;
          end
        end else begin
          bidx_nxt = bidx_r + 3'd1;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          bidx_nxt  = '0;
          phase_nxt = PH_BITS;
        end
      end
      PH_BITS: begin
        res.message_taken = (bidx_r == '0);
        res.stego_byte    = {image_byte[7:1], b[0]};
        shift_nxt         = {1'b0, b[7:1]};
        if (bidx_r == LAST_BIT) begin
          bidx_nxt  = '0;
          chars_nxt = chars_inc;
          if (chars_inc >= cfg.message_length) begin
            phase_nxt = PH_DONE;
          end else begin
            skip_nxt  = sn_skip;
            kidx_nxt  = sn_kidx;
            phase_nxt = sn_phase;
          end
        end else begin
          bidx_nxt = bidx_r + 3'd1;
        end
      end
      PH_DONE: ;
      default: phase_nxt = PH_DONE;
    endcase

    res.embed_done = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      bpos_r  <= '0;
      hlen_r  <= '0;
      skip_r  <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      chars_r <= '0;
      kidx_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      hlen_r  <= hlen_nxt;
      skip_r  <= skip_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      chars_r <= chars_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

endmodule

// ===== design/keyed_lsb_embedder_unit.sv =====
// Keyed LSB embedder: hides a message in the least significant bits of an
// image byte stream. Bytes 0..10 and the rest of the header (length taken
// from byte 10) pass unchanged; the next eight bytes carry message_length in
// their LSBs, bit 0 first; then for each message byte the block passes as
// many bytes as the current key byte says (key used cyclically, key_length
// clamped to KEY_BYTES, zero means no skipping) and writes the eight message
// bits into the next eight LSBs, consuming message_byte on the first of them.
// Afterward the stream passes through and embed_done stays high. Every input
// item yields exactly one result item. Throughput is one item per clock
// while out_tready is high; the single result register also lets a new
// item in while an unread result waits when out_tready is high.
// Registers are written through cfg_we/cfg_addr/cfg_wdata and must only be
// changed while the stream is idle.
module keyed_lsb_embedder_unit #(
  parameter int KEY_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [7:0] image_byte, [15:8] message_byte
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [7:0] stego_byte, [8] message_taken,
                                                     // [9] embed_done, [15:10] zero
  // config write port
  input  logic                           cfg_we,
  input  logic [kle_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [kle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kle_pkg::*;

  kle_cfg_t cfg;
  kle_res_t res;
  kle_res_t res_r;
  logic     out_valid_r;
  logic     step;

  // Take a new item whenever the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  kle_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kle_core #(
    .KEY_BYTES (KEY_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .image_byte   (in_tdata[7:0]),
    .message_byte (in_tdata[15:8]),
    .cfg          (cfg),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r};

endmodule

// ===== sim/tb.sv =====
module tb;
  import kle_pkg::*;

  localparam int KEY_BYTES = 16;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int HANG_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  keyed_lsb_embedder_unit #(.KEY_BYTES(KEY_BYTES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Embedder shadow: registers and stream state, as the block holds them after reset
  // ---------------------------------------------------------------------
  logic [7:0]   msg_len = '0;
  logic [127:0] key_word = '0;      // key byte k in bits 8k+7..8k
  logic [4:0]   key_len = '0;

  phase_t       ph = PH_HEADER;
  logic [7:0]   hdr_pos = '0;
  logic [7:0]   hdr_len = '0;
  logic [7:0]   skip_left = '0;
  logic [2:0]   bit_idx = '0;
  logic [7:0]   shift_reg = '0;
  logic [7:0]   chars_done = '0;
  int           key_idx = 0;

  kle_res_t     stego_q[$];         // expected results, oldest first
  int           errors = 0;
  int           items_sent = 0;
  int           bytes_taken = 0;
  int           skip_bytes = 0;
  bit           no_gaps = 1'b0;     // both sides run flat out while set

  // Skip for the next message byte; key wraps at min(key_len, KEY_BYTES).
  function void load_skip();
    int          n;
    logic [7:0]  s;
    n = (key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len);
    s = '0;
    if (n != 0) begin
      if (key_idx >= n) key_idx = 0;
      s = key_word[key_idx*8 +: 8];
      key_idx++;
      if (key_idx >= n) key_idx = 0;
    end
    skip_left = s;
    bit_idx = '0;
    ph = (s != 8'd0) ? PH_SKIP : PH_BITS;
  endfunction

  // One image byte in, one stego result out; advances the shadow state.
  function kle_res_t embed_predict(input logic [7:0] img, input logic [7:0] msg);
    kle_res_t   r;
    logic [7:0] b;
    r.stego_byte = img;
    r.message_taken = 1'b0;
    case (ph)
      PH_HEADER: begin
        if (hdr_pos == HDR_LEN_POS) hdr_len = img;
        // bytes 0..10 always pass, so a short header still ends at byte 10
        if (hdr_pos >= HDR_LEN_POS && int'(hdr_pos) + 1 >= int'(hdr_len)) begin
          bit_idx = '0;
          ph = PH_LENGTH;
        end else begin
          hdr_pos = hdr_pos + 8'd1;
        end
      end
      PH_LENGTH: begin
        r.stego_byte = {img[7:1], msg_len[bit_idx]};
        if (bit_idx == LAST_BIT) begin
          bit_idx = '0;
          if (chars_done >= msg_len) ph = PH_DONE;
          else load_skip();
        end else begin
          bit_idx = bit_idx + 3'd1;
        end
      end
      PH_SKIP: begin
        skip_bytes++;
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) begin
          bit_idx = '0;
          ph = PH_BITS;
        end
      end
      PH_BITS: begin
        if (bit_idx == 3'd0) begin
          b = msg;
          r.message_taken = 1'b1;
        end else begin
          b = shift_reg;
        end
        r.stego_byte = {img[7:1], b[0]};
        shift_reg = b >> 1;
        if (bit_idx == LAST_BIT) begin
          bit_idx = '0;
          chars_done = chars_done + 8'd1;
          // live length: a length lowered mid-stream stops here too
          if (chars_done >= msg_len) ph = PH_DONE;
          else load_skip();
        end else begin
          bit_idx = bit_idx + 3'd1;
        end
      end
      default: ph = PH_DONE;
    endcase
    r.embed_done = (ph == PH_DONE);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly short skips, now and then a long one.
  function logic [63:0] rand_key();
    logic [63:0] k;
    int          r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) k[i*8 +: 8] = 8'($urandom_range(0, 3));
      else if (r < 9) k[i*8 +: 8] = 8'($urandom_range(4, 15));
      else k[i*8 +: 8] = 8'($urandom_range(16, 255));
    end
    return k;
  endfunction

  // Present one item and wait for it to be taken. tvalid stays high after
  // the handshake; a gap or stop_stream lowers it at the next falling edge.
  task automatic send_image_byte(input logic [7:0] img, input logic [7:0] msg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {msg, img};
    do @(posedge clk); while (!in_tready);
    stego_q.push_back(embed_predict(img, msg));
    items_sent++;
  endtask

  task automatic stop_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_burst(input int n);
    repeat (n) send_image_byte(8'($urandom()), 8'($urandom()));
    stop_stream();
  endtask

  // Every item yields one result, so an empty queue means the block is idle.
  task automatic drain_results();
    while (stego_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MESSAGE_LENGTH: msg_len = val[7:0];
      REG_KEY_LOW:        key_word[63:0] = val;
      REG_KEY_HIGH:       key_word[127:64] = val;
      REG_KEY_LENGTH:     key_len = val[4:0];
      default: ;
    endcase
  endtask

  // Write the key registers between bursts; upper write bits are junk.
  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
    drain_results();
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LENGTH, {$urandom(), 27'($urandom()), len});
  endtask

  // ---------------------------------------------------------------------
  // Sink side: random tready stalls, mostly short, a few long
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(negedge clk) begin
    if (no_gaps) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 15) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(9, 39);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Result check: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    kle_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stego_q.size() == 0) begin
        $display("%0t: unexpected result, nothing pending: actual tdata %h", $time, out_tdata);
        errors++;
      end else begin
        want = stego_q.pop_front();
        if (out_tdata[7:0] !== want.stego_byte) begin
          $display("%0t: stego_byte expected %h actual %h", $time, want.stego_byte,
                   out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[8] !== want.message_taken) begin
          $display("%0t: message_taken expected %b actual %b", $time, want.message_taken,
                   out_tdata[8]);
          errors++;
        end
        if (out_tdata[9] !== want.embed_done) begin
          $display("%0t: embed_done expected %b actual %b", $time, want.embed_done,
                   out_tdata[9]);
          errors++;
        end
        if (out_tdata[15:10] !== 6'd0) begin
          $display("%0t: tdata pad expected 00 actual %h", $time, out_tdata[15:10]);
          errors++;
        end
        if (want.message_taken) bytes_taken++;
      end
    end
  end

  // Hang watchdog: counts cycles without a handshake on either channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results pending", $time,
               idle_cycles, stego_q.size());
      $display("keyed_lsb_embedder_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Full length (all ones in the length bits), key length above KEY_BYTES,
  // key byte 0 zero so the first message byte has no skip.
  task automatic test_setup();
    logic [63:0] lo;
    lo = rand_key();
    lo[7:0] = 8'd0;
    lo[15:8] = 8'd1;
    write_reg(REG_MESSAGE_LENGTH, {$urandom(), 24'($urandom()), 8'd255});
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, rand_key());
    write_reg(REG_KEY_LENGTH, {$urandom(), 27'($urandom()), 5'd31});
  endtask

  // Header bytes at the extremes, the header length byte, the rest of the header,
  // then the eight length bytes. Header lengths up to 11 exercise the short-header rule.
  task automatic test_header();
    logic [7:0] hl;
    hl = 8'($urandom_range(0, 20));
    for (int i = 0; i < 10; i++)
      send_image_byte(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF);
    send_image_byte(hl, 8'($urandom()));
    while (ph == PH_HEADER) send_image_byte(8'($urandom()), 8'($urandom()));
    for (int i = 0; i < 8; i++)
      send_image_byte(i[0] ? 8'h00 : 8'hFF, 8'($urandom()));
    stop_stream();
  endtask

  // Random image and message bytes under several key settings.
  task automatic test_keys();
    send_burst(250);
    // no skipping, no idling on either side
    set_key(rand_key(), rand_key(), 5'd0);
    no_gaps = 1'b1;
    send_burst(250);
    drain_results();
    no_gaps = 1'b0;
    set_key(rand_key(), rand_key(), 5'd16);
    send_burst(250);
    // longest skips, every key bit set
    set_key('1, '1, 5'd1);
    send_burst(300);
    set_key(rand_key(), rand_key(), 5'($urandom_range(1, 16)));
    send_burst(250);
  endtask

  // Sender holds off mid-stream until every pending result is out.
  task automatic test_pause();
    send_burst(80);
    drain_results();
    repeat ($urandom_range(2, 12)) @(negedge clk);
    send_burst(80);
  endtask

  // All-zero key, then the message length is cut: either to two bytes past
  // what is embedded (stop on reaching it) or to zero (already exceeded).
  task automatic test_stop();
    logic [7:0] cut;
    set_key('0, '0, 5'd16);
    send_burst(60);
    drain_results();
    cut = ($urandom_range(0, 1) != 0) ? chars_done + 8'd2 : 8'd0;
    write_reg(REG_MESSAGE_LENGTH, {$urandom(), 24'($urandom()), cut});
    send_burst(100);
    drain_results();
    write_reg(REG_MESSAGE_LENGTH, {$urandom(), 24'($urandom()), 8'd0});
    send_burst(50);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_setup();
    test_header();
    test_keys();
    test_pause();
    test_stop();
    drain_results();
    repeat (8) @(posedge clk);
    $display("ran %0d image bytes: header of %0d, %0d message bytes taken, %0d skipped bytes",
             items_sent, int'(hdr_pos) + 1, bytes_taken, skip_bytes);
    $display("key lengths 0, 1, 16 and 31 used; embedding done flag %0d", ph == PH_DONE);
    if (errors == 0) begin
      $display("keyed_lsb_embedder_unit: match");
    end else begin
      $display("keyed_lsb_embedder_unit: mismatch");
    end
    $finish;
  end

endmodule
